>>> rtl/core/alse_pkg.sv
// Package of the address lease server engine.
// Holds the client entry, request word and result word types, the controller states and the protocol codes.
// It depends on nothing else.
`default_nettype none
package alse_pkg;

   localparam logic [1:0] CMD_MESSAGE = 2'd0;
   localparam logic [1:0] CMD_TICK    = 2'd1;
   localparam logic [1:0] CMD_POOL    = 2'd2;
   localparam logic [1:0] CMD_SPARE   = 2'd3;

   localparam logic [1:0] PH_WAIT = 2'd0;
   localparam logic [1:0] PH_USE  = 2'd1;
   localparam logic [1:0] PH_RTO  = 2'd2;

   localparam logic [7:0] T_NONE     = 8'd0;
   localparam logic [7:0] T_DISCOVER = 8'd1;
   localparam logic [7:0] T_OFFER    = 8'd2;
   localparam logic [7:0] T_REQUEST  = 8'd3;
   localparam logic [7:0] T_ACK      = 8'd4;
   localparam logic [7:0] T_RELEASE  = 8'd5;

   localparam logic [7:0] C_OK      = 8'd0;
   localparam logic [7:0] C_NO_ADDR = 8'd1;
   localparam logic [7:0] C_ALLOC   = 8'd2;
   localparam logic [7:0] C_EXTEND  = 8'd3;
   localparam logic [7:0] C_REFUSED = 8'd4;

   localparam logic [3:0] OC_OFFERED     = 4'd0;
   localparam logic [3:0] OC_REFUSED     = 4'd1;
   localparam logic [3:0] OC_ACKED       = 4'd2;
   localparam logic [3:0] OC_ACK_REFUSED = 4'd3;
   localparam logic [3:0] OC_CLOSED      = 4'd4;
   localparam logic [3:0] OC_RELEASED    = 4'd5;
   localparam logic [3:0] OC_EXPIRED     = 4'd6;
   localparam logic [3:0] OC_IGNORED     = 4'd7;
   localparam logic [3:0] OC_POOL_ADDED  = 4'd8;
   localparam logic [3:0] OC_POOL_FULL   = 4'd9;
   localparam logic [3:0] OC_RESENT      = 4'd10;
   localparam logic [3:0] OC_TICK_DONE   = 4'd11;

   localparam logic signed [16:0] CNT_MIN = -17'sd65536;

   typedef struct packed {
      logic               valid;
      logic [1:0]         phase;
      logic [31:0]        ip;
      logic [15:0]        port;
      logic signed [16:0] cnt;
      logic [63:0]        pair;
      logic [15:0]        offer_ttl;
   } entry_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] client_ip;
      logic [15:0] src_port;
      logic [7:0]  msg_type;
      logic [7:0]  msg_code;
      logic [15:0] msg_ttl;
      logic [63:0] msg_pair;
   } item_type;

   typedef struct packed {
      logic        has_reply;
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
      logic [7:0]  reply_type;
      logic [7:0]  reply_code;
      logic [15:0] reply_ttl;
      logic [31:0] reply_address;
      logic [31:0] reply_netmask;
      logic [3:0]  outcome;
      logic        last;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_APPLY,
      ST_TICK,
      ST_TDONE,
      ST_SINGLE
   } state_type;

endpackage
`default_nettype wire

>>> rtl/core/alse_req_if.sv
// Request channel interface of the address lease server engine.
// Carries valid, ready and the fields of one request word; no dependencies.
`default_nettype none
interface alse_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] client_ip;
   logic [15:0] src_port;
   logic [7:0]  msg_type;
   logic [7:0]  msg_code;
   logic [15:0] msg_ttl;
   logic [31:0] msg_address;
   logic [31:0] msg_netmask;

   modport source (output valid, command, client_ip, src_port, msg_type, msg_code,
                   msg_ttl, msg_address, msg_netmask, input ready);
   modport sink (input valid, command, client_ip, src_port, msg_type, msg_code,
                 msg_ttl, msg_address, msg_netmask, output ready);
endinterface
`default_nettype wire

>>> rtl/core/alse_rsp_if.sv
// Response channel interface of the address lease server engine.
// Carries valid, ready and the fields of one response word; no dependencies.
`default_nettype none
interface alse_rsp_if;
   logic        valid;
   logic        ready;
   logic        has_reply;
   logic [31:0] dest_ip;
   logic [15:0] dest_port;
   logic [7:0]  reply_type;
   logic [7:0]  reply_code;
   logic [15:0] reply_ttl;
   logic [31:0] reply_address;
   logic [31:0] reply_netmask;
   logic [3:0]  outcome;
   logic        last;

   modport source (output valid, has_reply, dest_ip, dest_port, reply_type, reply_code,
                   reply_ttl, reply_address, reply_netmask, outcome, last, input ready);
   modport sink (input valid, has_reply, dest_ip, dest_port, reply_type, reply_code,
                 reply_ttl, reply_address, reply_netmask, outcome, last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/address_lease_server_engine.sv
// Top level of the address lease server engine: controller, client ring and address pool.
// Uses alse_pkg, alse_req_if, alse_rsp_if and alse_cell.
//
// The client table is a ring of CLIENT_SLOTS cells that rotates by one slot per cycle past a
// single head position where the controller reads and rewrites an entry, so slots are visited
// in index order. In a tick the ring holds while an expiring entry awaits the output register.
// A client message that changes the table passes the accept cycle, one lookup revolution, a
// decision cycle and one write-back revolution; one that leaves the table unchanged skips the
// write-back. A tick passes the accept cycle, one revolution and a closing state, and a pool
// entry the accept cycle and a single-word state. Each of these stalls while a finished
// response word finds the output register still full. One request word is handled at a time;
// a finished response word waits in the output register while the next request is accepted.
`default_nettype none
module address_lease_server_engine #(
   parameter int CLIENT_SLOTS = 16,
   parameter int POOL_DEPTH   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   alse_req_if.sink         req_chan,
   alse_rsp_if.source       rsp_chan
);
   localparam int SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
   localparam int PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = $clog2(POOL_DEPTH + 1);

   alse_pkg::state_type state_ff, state_in;
   logic [SW-1:0]       step_ff, step_in;
   logic [15:0]         lease_ff;
   alse_pkg::item_type  item_ff;

   logic                hit_ff, free_ff;
   logic [SW-1:0]       hit_idx_ff, free_idx_ff, tgt_idx_ff, tgt_idx_in;
   alse_pkg::entry_type hit_e_ff, tgt_e_ff, tgt_e_in;
   logic                apply_req;

   alse_pkg::entry_type ring_q [CLIENT_SLOTS];
   alse_pkg::entry_type ring_d [CLIENT_SLOTS];
   alse_pkg::entry_type head, head_new;
   logic                shift_en;

   logic [63:0]   pool_mem [POOL_DEPTH];
   logic [63:0]   pool_q_ff;
   logic [PW-1:0] pool_head_ff, pool_tail_ff;
   logic [CW-1:0] pool_count_ff;
   logic          push_en, pop_en, pool_room;
   logic [63:0]   push_pair;

   alse_pkg::result_type out_ff, res;
   logic                 out_valid_ff, load, can_load;

   logic                accept, last_step;
   logic signed [16:0]  cnt_dec, half_lease, full_lease;
   logic                match_pair, ttl_ok;

   assign accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == alse_pkg::ST_IDLE);
   assign can_load   = !out_valid_ff || rsp_chan.ready;
   assign last_step  = (step_ff == SW'(CLIENT_SLOTS - 1));
   assign head       = ring_q[0];
   assign pool_room  = (pool_count_ff < CW'(POOL_DEPTH));
   assign half_lease = 17'({1'b0, lease_ff[15:1]});
   assign full_lease = 17'({1'b0, lease_ff});
   assign cnt_dec    = (head.cnt != alse_pkg::CNT_MIN) ? head.cnt - 17'sd1 : head.cnt;
   assign match_pair = (item_ff.msg_pair == hit_e_ff.pair);
   assign ttl_ok     = (item_ff.msg_ttl <= lease_ff);

   genvar g;
   generate
      for (g = 0; g < CLIENT_SLOTS; g++) begin : g_ring
         if (g == CLIENT_SLOTS - 1) begin : g_tail
            assign ring_d[g] = head_new;
         end else begin : g_mid
            assign ring_d[g] = ring_q[g+1];
         end
         alse_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .d_in     (ring_d[g]),
            .q_out    (ring_q[g])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         alse_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_chan.command)
                  alse_pkg::CMD_MESSAGE: state_in = alse_pkg::ST_SCAN;
                  alse_pkg::CMD_TICK:    state_in = alse_pkg::ST_TICK;
                  default:               state_in = alse_pkg::ST_SINGLE;
               endcase
            end
         end
         alse_pkg::ST_SCAN: begin
            step_in = last_step ? '0 : step_ff + SW'(1);
            if (last_step) state_in = alse_pkg::ST_DECIDE;
         end
         alse_pkg::ST_DECIDE: begin
            if (can_load) state_in = apply_req ? alse_pkg::ST_APPLY : alse_pkg::ST_IDLE;
         end
         alse_pkg::ST_APPLY: begin
            step_in = last_step ? '0 : step_ff + SW'(1);
            if (last_step) state_in = alse_pkg::ST_IDLE;
         end
         alse_pkg::ST_TICK: begin
            if (shift_en) begin
               step_in = last_step ? '0 : step_ff + SW'(1);
               if (last_step) state_in = alse_pkg::ST_TDONE;
            end
         end
         alse_pkg::ST_TDONE: begin
            if (can_load) state_in = alse_pkg::ST_IDLE;
         end
         alse_pkg::ST_SINGLE: begin
            if (can_load) state_in = alse_pkg::ST_IDLE;
         end
         default: state_in = alse_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      shift_en   = 1'b0;
      head_new   = head;
      push_en    = 1'b0;
      push_pair  = hit_e_ff.pair;
      pop_en     = 1'b0;
      load       = 1'b0;
      res        = '0;
      apply_req  = 1'b0;
      tgt_e_in   = hit_e_ff;
      tgt_idx_in = hit_idx_ff;
      case (state_ff)
         alse_pkg::ST_SCAN: begin
            shift_en = 1'b1;
         end
         alse_pkg::ST_APPLY: begin
            shift_en = 1'b1;
            if (step_ff == tgt_idx_ff) head_new = tgt_e_ff;
         end
         alse_pkg::ST_TICK: begin
            if (!head.valid) begin
               shift_en = 1'b1;
            end else if (!cnt_dec[16]) begin
               shift_en     = 1'b1;
               head_new.cnt = cnt_dec;
            end else if (can_load) begin
               shift_en      = 1'b1;
               load          = 1'b1;
               res.dest_ip   = head.ip;
               res.dest_port = head.port;
               if (head.phase == alse_pkg::PH_WAIT) begin
                  head_new.phase    = alse_pkg::PH_RTO;
                  head_new.cnt      = half_lease;
                  res.has_reply     = 1'b1;
                  res.reply_type    = alse_pkg::T_OFFER;
                  res.reply_code    = alse_pkg::C_OK;
                  res.reply_ttl     = head.offer_ttl;
                  res.reply_address = head.pair[63:32];
                  res.reply_netmask = head.pair[31:0];
                  res.outcome       = alse_pkg::OC_RESENT;
               end else begin
                  head_new.valid = 1'b0;
                  push_en        = pool_room;
                  push_pair      = head.pair;
                  res.outcome    = alse_pkg::OC_EXPIRED;
               end
            end
         end
         alse_pkg::ST_TDONE: begin
            load        = can_load;
            res.outcome = alse_pkg::OC_TICK_DONE;
            res.last    = 1'b1;
         end
         alse_pkg::ST_SINGLE: begin
            load      = can_load;
            res.last  = 1'b1;
            push_pair = item_ff.msg_pair;
            if (item_ff.command == alse_pkg::CMD_POOL) begin
               push_en     = can_load && pool_room;
               res.outcome = pool_room ? alse_pkg::OC_POOL_ADDED : alse_pkg::OC_POOL_FULL;
            end else begin
               res.outcome = alse_pkg::OC_IGNORED;
            end
         end
         alse_pkg::ST_DECIDE: begin
            load          = can_load;
            res.last      = 1'b1;
            res.dest_ip   = item_ff.client_ip;
            res.dest_port = item_ff.src_port;
            res.outcome   = alse_pkg::OC_CLOSED;
            if (!hit_ff) begin
               if (item_ff.msg_type != alse_pkg::T_DISCOVER) begin
                  res.outcome = alse_pkg::OC_IGNORED;
               end else if (pool_count_ff == '0 || !free_ff) begin
                  res.has_reply  = 1'b1;
                  res.reply_type = alse_pkg::T_OFFER;
                  res.reply_code = alse_pkg::C_NO_ADDR;
                  res.outcome    = alse_pkg::OC_REFUSED;
               end else begin
                  apply_req          = 1'b1;
                  pop_en             = can_load;
                  tgt_idx_in         = free_idx_ff;
                  tgt_e_in.valid     = 1'b1;
                  tgt_e_in.phase     = alse_pkg::PH_WAIT;
                  tgt_e_in.ip        = item_ff.client_ip;
                  tgt_e_in.port      = item_ff.src_port;
                  tgt_e_in.cnt       = half_lease;
                  tgt_e_in.offer_ttl = lease_ff;
                  tgt_e_in.pair      = pool_q_ff;
                  res.has_reply      = 1'b1;
                  res.reply_type     = alse_pkg::T_OFFER;
                  res.reply_code     = alse_pkg::C_OK;
                  res.reply_ttl      = lease_ff;
                  res.reply_address  = pool_q_ff[63:32];
                  res.reply_netmask  = pool_q_ff[31:0];
                  res.outcome        = alse_pkg::OC_OFFERED;
               end
            end else begin
               apply_req      = 1'b1;
               tgt_e_in.valid = 1'b0;
               push_en        = can_load && pool_room;
               if (hit_e_ff.phase == alse_pkg::PH_WAIT || hit_e_ff.phase == alse_pkg::PH_RTO) begin
                  if (item_ff.msg_type == alse_pkg::T_REQUEST &&
                      item_ff.msg_code == alse_pkg::C_ALLOC) begin
                     res.has_reply     = 1'b1;
                     res.reply_type    = alse_pkg::T_ACK;
                     res.reply_address = hit_e_ff.pair[63:32];
                     res.reply_netmask = hit_e_ff.pair[31:0];
                     if (match_pair && ttl_ok) begin
                        push_en        = 1'b0;
                        tgt_e_in.valid = 1'b1;
                        tgt_e_in.phase = alse_pkg::PH_USE;
                        tgt_e_in.cnt   = full_lease;
                        res.reply_code = alse_pkg::C_OK;
                        res.reply_ttl  = hit_e_ff.offer_ttl;
                        res.outcome    = alse_pkg::OC_ACKED;
                     end else begin
                        res.reply_code = alse_pkg::C_REFUSED;
                        res.outcome    = alse_pkg::OC_ACK_REFUSED;
                     end
                  end
               end else if (hit_e_ff.phase == alse_pkg::PH_USE) begin
                  if (item_ff.msg_type == alse_pkg::T_REQUEST &&
                      item_ff.msg_code == alse_pkg::C_EXTEND) begin
                     push_en           = 1'b0;
                     tgt_e_in.valid    = 1'b1;
                     tgt_e_in.cnt      = full_lease;
                     res.has_reply     = 1'b1;
                     res.reply_type    = alse_pkg::T_ACK;
                     res.reply_code    = alse_pkg::C_OK;
                     res.reply_ttl     = hit_e_ff.offer_ttl;
                     res.reply_address = hit_e_ff.pair[63:32];
                     res.reply_netmask = hit_e_ff.pair[31:0];
                     res.outcome       = alse_pkg::OC_ACKED;
                  end else if (item_ff.msg_type == alse_pkg::T_RELEASE) begin
                     if (match_pair) begin
                        res.outcome = alse_pkg::OC_RELEASED;
                     end else begin
                        push_en     = 1'b0;
                        apply_req   = 1'b0;
                        res.outcome = alse_pkg::OC_IGNORED;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= alse_pkg::ST_IDLE;
         step_ff       <= '0;
         lease_ff      <= 16'd60;
         out_valid_ff  <= 1'b0;
         pool_head_ff  <= '0;
         pool_tail_ff  <= '0;
         pool_count_ff <= '0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_we) lease_ff <= csr_wdata;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (push_en) begin
            pool_tail_ff <= (pool_tail_ff == PW'(POOL_DEPTH - 1)) ? '0 : pool_tail_ff + PW'(1);
         end
         if (pop_en) begin
            pool_head_ff <= (pool_head_ff == PW'(POOL_DEPTH - 1)) ? '0 : pool_head_ff + PW'(1);
         end
         if (push_en && !pop_en) begin
            pool_count_ff <= pool_count_ff + CW'(1);
         end else if (pop_en && !push_en) begin
            pool_count_ff <= pool_count_ff - CW'(1);
         end
         if (accept) begin
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else if (state_ff == alse_pkg::ST_SCAN) begin
            if (head.valid && !hit_ff && head.ip == item_ff.client_ip &&
                head.port == item_ff.src_port) begin
               hit_ff <= 1'b1;
            end
            if (!head.valid && !free_ff) free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.command   <= req_chan.command;
         item_ff.client_ip <= req_chan.client_ip;
         item_ff.src_port  <= req_chan.src_port;
         item_ff.msg_type  <= req_chan.msg_type;
         item_ff.msg_code  <= req_chan.msg_code;
         item_ff.msg_ttl   <= req_chan.msg_ttl;
         item_ff.msg_pair  <= {req_chan.msg_address, req_chan.msg_netmask};
      end
      if (state_ff == alse_pkg::ST_SCAN) begin
         if (head.valid && !hit_ff && head.ip == item_ff.client_ip &&
             head.port == item_ff.src_port) begin
            hit_idx_ff <= step_ff;
            hit_e_ff   <= head;
         end
         if (!head.valid && !free_ff) free_idx_ff <= step_ff;
      end
      if (state_ff == alse_pkg::ST_DECIDE) begin
         tgt_idx_ff <= tgt_idx_in;
         tgt_e_ff   <= tgt_e_in;
      end
      if (load) out_ff <= res;
   end

   always_ff @(posedge clock) begin
      if (push_en) pool_mem[pool_tail_ff] <= push_pair;
      pool_q_ff <= pool_mem[pool_head_ff];
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.has_reply     = out_ff.has_reply;
   assign rsp_chan.dest_ip       = out_ff.dest_ip;
   assign rsp_chan.dest_port     = out_ff.dest_port;
   assign rsp_chan.reply_type    = out_ff.reply_type;
   assign rsp_chan.reply_code    = out_ff.reply_code;
   assign rsp_chan.reply_ttl     = out_ff.reply_ttl;
   assign rsp_chan.reply_address = out_ff.reply_address;
   assign rsp_chan.reply_netmask = out_ff.reply_netmask;
   assign rsp_chan.outcome       = out_ff.outcome;
   assign rsp_chan.last          = out_ff.last;

   a_idle_home: assert property (@(posedge clock) disable iff (reset)
      state_ff == alse_pkg::ST_IDLE |-> step_ff == '0)
      else $error("Client ring is not back home while idle.");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      pool_count_ff <= CW'(POOL_DEPTH))
      else $error("Pool count exceeds the pool depth.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(load && out_valid_ff && !rsp_chan.ready))
      else $error("Pending response word overwritten.");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop_en |-> pool_count_ff != '0)
      else $error("Pool pop while the pool is empty.");
endmodule
`default_nettype wire

>>> rtl/core/alse_cell.sv
// One client slot of the rotating client ring.
// Loads the entry of its neighbor when the ring shifts; uses alse_pkg.
`default_nettype none
module alse_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               shift_en,
   input  wire alse_pkg::entry_type d_in,
   output alse_pkg::entry_type     q_out
);
   logic                valid_ff;
   alse_pkg::entry_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= d_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= d_in;
      end
   end

   always_comb begin
      q_out       = data_ff;
      q_out.valid = valid_ff;
   end
endmodule
`default_nettype wire

>>> bench/tb_address_lease_server_engine.sv
// Self-checking bench for address_lease_server_engine: a lease table predictor inside a small
// scoreboard class, random handshake gaps on both channels, and lease_time phases.
// Depends on alse_pkg, alse_req_if, alse_rsp_if and the engine RTL.
`timescale 1ns / 100ps
module tb_address_lease_server_engine;

   localparam int SLOTS      = 16;
   localparam int DEPTH      = 16;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE     = 40;

   class lease_scoreboard;
      logic               valid [SLOTS];
      logic [1:0]         phase [SLOTS];
      logic [31:0]        ip [SLOTS];
      logic [15:0]        port [SLOTS];
      int                 cnt [SLOTS];
      logic [63:0]        pair [SLOTS];
      logic [15:0]        offer_ttl [SLOTS];
      logic [63:0]        pool [DEPTH];
      int                 head, tail, count;
      logic [15:0]        lease;
      alse_pkg::result_type awaited[$];
      int                 errors;

      function new();
         lease = 16'd60;
         head = 0;
         tail = 0;
         count = 0;
         errors = 0;
         foreach (valid[i]) valid[i] = 1'b0;
      endfunction

      function void push_result(logic has, logic [31:0] dip, logic [15:0] dport,
                                logic [7:0] rtype, logic [7:0] rcode, logic [15:0] rttl,
                                logic [63:0] rpair, logic [3:0] oc, logic fin);
         alse_pkg::result_type r;
         r.has_reply = has;
         r.dest_ip = dip;
         r.dest_port = dport;
         r.reply_type = rtype;
         r.reply_code = rcode;
         r.reply_ttl = rttl;
         r.reply_address = rpair[63:32];
         r.reply_netmask = rpair[31:0];
         r.outcome = oc;
         r.last = fin;
         awaited.push_back(r);
      endfunction

      function bit pool_push(logic [63:0] p);
         if (count >= DEPTH) return 1'b0;
         pool[tail] = p;
         tail = (tail + 1) % DEPTH;
         count++;
         return 1'b1;
      endfunction

      function void close_slot(int i);
         void'(pool_push(pair[i]));
         valid[i] = 1'b0;
      endfunction

      function int find_client(logic [31:0] cip, logic [15:0] cport);
         for (int i = 0; i < SLOTS; i++)
            if (valid[i] && ip[i] == cip && port[i] == cport) return i;
         return -1;
      endfunction

      function void note_word(alse_pkg::item_type w);
         int hit;
         int free_slot;
         hit = -1;
         free_slot = -1;
         if (w.command == alse_pkg::CMD_TICK) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!valid[i]) continue;
               if (cnt[i] > -65536) cnt[i]--;
               if (cnt[i] >= 0) continue;
               if (phase[i] == alse_pkg::PH_WAIT) begin
                  phase[i] = alse_pkg::PH_RTO;
                  cnt[i] = int'(lease) / 2;
                  push_result(1'b1, ip[i], port[i], alse_pkg::T_OFFER, alse_pkg::C_OK,
                              offer_ttl[i], pair[i], alse_pkg::OC_RESENT, 1'b0);
               end else begin
                  close_slot(i);
                  push_result(1'b0, ip[i], port[i], alse_pkg::T_NONE, alse_pkg::C_OK, '0, '0,
                              alse_pkg::OC_EXPIRED, 1'b0);
               end
            end
            push_result(1'b0, '0, '0, alse_pkg::T_NONE, alse_pkg::C_OK, '0, '0,
                        alse_pkg::OC_TICK_DONE, 1'b1);
            return;
         end
         if (w.command == alse_pkg::CMD_POOL) begin
            push_result(1'b0, '0, '0, alse_pkg::T_NONE, alse_pkg::C_OK, '0, '0,
                        pool_push(w.msg_pair) ? alse_pkg::OC_POOL_ADDED :
                                                alse_pkg::OC_POOL_FULL, 1'b1);
            return;
         end
         if (w.command != alse_pkg::CMD_MESSAGE) begin
            push_result(1'b0, '0, '0, alse_pkg::T_NONE, alse_pkg::C_OK, '0, '0,
                        alse_pkg::OC_IGNORED, 1'b1);
            return;
         end
         for (int i = 0; i < SLOTS; i++) begin
            if (valid[i]) begin
               if (hit < 0 && ip[i] == w.client_ip && port[i] == w.src_port) hit = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (hit < 0) begin
            if (w.msg_type != alse_pkg::T_DISCOVER) begin
               push_result(1'b0, w.client_ip, w.src_port, alse_pkg::T_NONE, alse_pkg::C_OK,
                           '0, '0, alse_pkg::OC_IGNORED, 1'b1);
            end else if (count == 0 || free_slot < 0) begin
               push_result(1'b1, w.client_ip, w.src_port, alse_pkg::T_OFFER,
                           alse_pkg::C_NO_ADDR, '0, '0, alse_pkg::OC_REFUSED, 1'b1);
            end else begin
               valid[free_slot] = 1'b1;
               phase[free_slot] = alse_pkg::PH_WAIT;
               ip[free_slot] = w.client_ip;
               port[free_slot] = w.src_port;
               cnt[free_slot] = int'(lease) / 2;
               offer_ttl[free_slot] = lease;
               pair[free_slot] = pool[head];
               head = (head + 1) % DEPTH;
               count--;
               push_result(1'b1, w.client_ip, w.src_port, alse_pkg::T_OFFER, alse_pkg::C_OK,
                           lease, pair[free_slot], alse_pkg::OC_OFFERED, 1'b1);
            end
            return;
         end
         if (phase[hit] == alse_pkg::PH_WAIT || phase[hit] == alse_pkg::PH_RTO) begin
            if (w.msg_type == alse_pkg::T_REQUEST && w.msg_code == alse_pkg::C_ALLOC) begin
               if (w.msg_pair == pair[hit] && w.msg_ttl <= lease) begin
                  phase[hit] = alse_pkg::PH_USE;
                  cnt[hit] = int'(lease);
                  push_result(1'b1, w.client_ip, w.src_port, alse_pkg::T_ACK, alse_pkg::C_OK,
                              offer_ttl[hit], pair[hit], alse_pkg::OC_ACKED, 1'b1);
               end else begin
                  push_result(1'b1, w.client_ip, w.src_port, alse_pkg::T_ACK,
                              alse_pkg::C_REFUSED, '0, pair[hit], alse_pkg::OC_ACK_REFUSED,
                              1'b1);
                  close_slot(hit);
               end
            end else begin
               close_slot(hit);
               push_result(1'b0, w.client_ip, w.src_port, alse_pkg::T_NONE, alse_pkg::C_OK,
                           '0, '0, alse_pkg::OC_CLOSED, 1'b1);
            end
         end else if (phase[hit] == alse_pkg::PH_USE) begin
            if (w.msg_type == alse_pkg::T_REQUEST && w.msg_code == alse_pkg::C_EXTEND) begin
               cnt[hit] = int'(lease);
               push_result(1'b1, w.client_ip, w.src_port, alse_pkg::T_ACK, alse_pkg::C_OK,
                           offer_ttl[hit], pair[hit], alse_pkg::OC_ACKED, 1'b1);
            end else if (w.msg_type == alse_pkg::T_RELEASE) begin
               if (w.msg_pair == pair[hit]) begin
                  close_slot(hit);
                  push_result(1'b0, w.client_ip, w.src_port, alse_pkg::T_NONE,
                              alse_pkg::C_OK, '0, '0, alse_pkg::OC_RELEASED, 1'b1);
               end else begin
                  push_result(1'b0, w.client_ip, w.src_port, alse_pkg::T_NONE,
                              alse_pkg::C_OK, '0, '0, alse_pkg::OC_IGNORED, 1'b1);
               end
            end else begin
               close_slot(hit);
               push_result(1'b0, w.client_ip, w.src_port, alse_pkg::T_NONE, alse_pkg::C_OK,
                           '0, '0, alse_pkg::OC_CLOSED, 1'b1);
            end
         end else begin
            close_slot(hit);
            push_result(1'b0, w.client_ip, w.src_port, alse_pkg::T_NONE, alse_pkg::C_OK,
                        '0, '0, alse_pkg::OC_CLOSED, 1'b1);
         end
      endfunction

      function void check_word(alse_pkg::result_type got);
         alse_pkg::result_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %p", got);
            return;
         end
         want = awaited.pop_front();
         if (got.has_reply !== want.has_reply || got.dest_ip !== want.dest_ip ||
             got.dest_port !== want.dest_port || got.reply_type !== want.reply_type ||
             got.reply_code !== want.reply_code || got.reply_ttl !== want.reply_ttl ||
             got.reply_address !== want.reply_address ||
             got.reply_netmask !== want.reply_netmask || got.outcome !== want.outcome ||
             got.last !== want.last) begin
            errors++;
            if (errors <= 10) $display("result mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [15:0] csr_wdata;
   alse_req_if req_chan();
   alse_rsp_if rsp_chan();

   address_lease_server_engine u_top (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_chan(req_chan), .rsp_chan(rsp_chan));

   lease_scoreboard board;
   bit req_taken;
   int idle_cycles;
   bit stimulus_done;
   logic [31:0] known_ip [6];
   logic [15:0] known_port [6];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      alse_pkg::item_type w;
      alse_pkg::result_type r;
      idle_cycles++;
      if (!reset && req_chan.valid && req_chan.ready) begin
         w.command = req_chan.command;
         w.client_ip = req_chan.client_ip;
         w.src_port = req_chan.src_port;
         w.msg_type = req_chan.msg_type;
         w.msg_code = req_chan.msg_code;
         w.msg_ttl = req_chan.msg_ttl;
         w.msg_pair = {req_chan.msg_address, req_chan.msg_netmask};
         board.note_word(w);
         req_taken = 1'b1;
         idle_cycles = 0;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         r.has_reply = rsp_chan.has_reply;
         r.dest_ip = rsp_chan.dest_ip;
         r.dest_port = rsp_chan.dest_port;
         r.reply_type = rsp_chan.reply_type;
         r.reply_code = rsp_chan.reply_code;
         r.reply_ttl = rsp_chan.reply_ttl;
         r.reply_address = rsp_chan.reply_address;
         r.reply_netmask = rsp_chan.reply_netmask;
         r.outcome = rsp_chan.outcome;
         r.last = rsp_chan.last;
         board.check_word(r);
         idle_cycles = 0;
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         int run;
         int pause;
         run = $urandom_range(1, 12);
         pause = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
         if ($urandom_range(0, 7) == 0) begin
            run = $urandom_range(50, 150);
            pause = 0;
         end
         @(negedge clock);
         rsp_chan.ready = 1'b1;
         repeat (run - 1) @(negedge clock);
         if (pause > 0) begin
            @(negedge clock);
            rsp_chan.ready = 1'b0;
            repeat (pause - 1) @(negedge clock);
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("[address_lease_server_engine] ERROR");
      $finish;
   end

   function automatic alse_pkg::item_type make_word(logic [1:0] cmd, logic [31:0] cip,
                                                    logic [15:0] cport, logic [7:0] mtype,
                                                    logic [7:0] mcode, logic [15:0] mttl,
                                                    logic [63:0] mpair);
      alse_pkg::item_type w;
      w.command = cmd;
      w.client_ip = cip;
      w.src_port = cport;
      w.msg_type = mtype;
      w.msg_code = mcode;
      w.msg_ttl = mttl;
      w.msg_pair = mpair;
      return w;
   endfunction

   task automatic send_word(alse_pkg::item_type w);
      int gap;
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
            (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.command = w.command;
      req_chan.client_ip = w.client_ip;
      req_chan.src_port = w.src_port;
      req_chan.msg_type = w.msg_type;
      req_chan.msg_code = w.msg_code;
      req_chan.msg_ttl = w.msg_ttl;
      req_chan.msg_address = w.msg_pair[63:32];
      req_chan.msg_netmask = w.msg_pair[31:0];
      req_taken = 1'b0;
      do @(negedge clock); while (!req_taken);
   endtask

   task automatic write_lease(logic [15:0] value);
      req_chan.valid = 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      board.lease = value;
   endtask

   function automatic logic [63:0] random_pair();
      return {$urandom(), $urandom()};
   endfunction

   function automatic alse_pkg::item_type random_word();
      int pick;
      int c;
      int s;
      logic [63:0] p;
      pick = $urandom_range(0, 99);
      if (pick < 14)
         return make_word(alse_pkg::CMD_TICK, $urandom(), 16'($urandom()), 8'($urandom()),
                          8'($urandom()), 16'($urandom()), random_pair());
      if (pick < 16)
         return make_word(alse_pkg::CMD_SPARE, $urandom(), 16'($urandom()), 8'($urandom()),
                          8'($urandom()), 16'($urandom()), random_pair());
      if (pick < 24 || (pick < 40 && board.count < 3))
         return make_word(alse_pkg::CMD_POOL, $urandom(), 16'($urandom()), 8'($urandom()),
                          8'($urandom()), 16'($urandom()), random_pair());
      if (pick < 32)
         return make_word(alse_pkg::CMD_MESSAGE, $urandom(), 16'($urandom()),
                          ($urandom_range(0, 1) == 0) ? alse_pkg::T_DISCOVER : 8'($urandom()),
                          8'($urandom()), 16'($urandom()), random_pair());
      c = $urandom_range(0, 5);
      s = board.find_client(known_ip[c], known_port[c]);
      pick = $urandom_range(0, 99);
      if (s < 0)
         return make_word(alse_pkg::CMD_MESSAGE, known_ip[c], known_port[c],
                          (pick < 85) ? alse_pkg::T_DISCOVER : 8'($urandom()),
                          8'($urandom()), 16'($urandom()), random_pair());
      p = board.pair[s];
      if (pick < 10)
         return make_word(alse_pkg::CMD_MESSAGE, known_ip[c], known_port[c], 8'($urandom()),
                          8'($urandom()), 16'($urandom()), random_pair());
      if (board.phase[s] != alse_pkg::PH_USE) begin
         if (pick < 80)
            return make_word(alse_pkg::CMD_MESSAGE, known_ip[c], known_port[c],
                             alse_pkg::T_REQUEST, alse_pkg::C_ALLOC,
                             16'($urandom_range(0, board.lease)), p);
         if (pick < 87)
            return make_word(alse_pkg::CMD_MESSAGE, known_ip[c], known_port[c],
                             alse_pkg::T_REQUEST, alse_pkg::C_ALLOC, 16'($urandom()), p);
         return make_word(alse_pkg::CMD_MESSAGE, known_ip[c], known_port[c],
                          alse_pkg::T_REQUEST, alse_pkg::C_ALLOC,
                          16'($urandom_range(0, board.lease)),
                          p ^ (64'd1 << $urandom_range(0, 63)));
      end
      if (pick < 60)
         return make_word(alse_pkg::CMD_MESSAGE, known_ip[c], known_port[c],
                          alse_pkg::T_REQUEST, alse_pkg::C_EXTEND, 16'($urandom()),
                          random_pair());
      if (pick < 78)
         return make_word(alse_pkg::CMD_MESSAGE, known_ip[c], known_port[c],
                          alse_pkg::T_RELEASE, 8'($urandom()), 16'($urandom()), p);
      if (pick < 90)
         return make_word(alse_pkg::CMD_MESSAGE, known_ip[c], known_port[c],
                          alse_pkg::T_RELEASE, 8'($urandom()), 16'($urandom()),
                          p ^ (64'd1 << $urandom_range(0, 63)));
      return make_word(alse_pkg::CMD_MESSAGE, known_ip[c], known_port[c],
                       alse_pkg::T_REQUEST, 8'($urandom()), 16'($urandom()), random_pair());
   endfunction

   initial begin
      logic [15:0] lease_plan [5];
      logic [63:0] p;
      board = new();
      lease_plan = '{16'd0, 16'd3, 16'd65535, 16'd10, 16'd60};
      known_ip = '{32'h0, 32'hFFFF_FFFF, 32'h0A00_0001, 32'h0A00_0001, 32'hC0A8_0102,
                   32'h7F00_0001};
      known_port = '{16'h0, 16'hFFFF, 16'd68, 16'd69, 16'd68, 16'h8000};
      idle_cycles = 0;
      stimulus_done = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.command = '0;
      req_chan.client_ip = '0;
      req_chan.src_port = '0;
      req_chan.msg_type = '0;
      req_chan.msg_code = '0;
      req_chan.msg_ttl = '0;
      req_chan.msg_address = '0;
      req_chan.msg_netmask = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h0, 16'h0, alse_pkg::T_DISCOVER,
                          '0, '0, '0));
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h0, 16'h0, alse_pkg::T_REQUEST,
                          alse_pkg::C_ALLOC, '0, '0));
      send_word(make_word(alse_pkg::CMD_SPARE, '1, '1, '1, '1, '1, '1));
      send_word(make_word(alse_pkg::CMD_POOL, '0, '0, '0, '0, '0, 64'h0));
      send_word(make_word(alse_pkg::CMD_POOL, '0, '0, '0, '0, '0, '1));
      send_word(make_word(alse_pkg::CMD_POOL, '0, '0, '0, '0, '0, 64'h0A00_0005_FFFF_FF00));
      send_word(make_word(alse_pkg::CMD_POOL, '0, '0, '0, '0, '0, 64'h0A00_0006_FFFF_FF00));
      send_word(make_word(alse_pkg::CMD_MESSAGE, '1, '1, alse_pkg::T_DISCOVER, '1, '1, '1));
      send_word(make_word(alse_pkg::CMD_MESSAGE, '1, '1, alse_pkg::T_REQUEST,
                          alse_pkg::C_ALLOC, 16'd61, '1));
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h0, 16'h0, alse_pkg::T_DISCOVER,
                          '0, '0, '0));
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h0, 16'h0, alse_pkg::T_REQUEST,
                          alse_pkg::C_ALLOC, 16'd60, 64'h1));
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h1, 16'h1, alse_pkg::T_DISCOVER,
                          '0, '0, '0));
      p = board.pair[board.find_client(32'h1, 16'h1)];
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h1, 16'h1, alse_pkg::T_REQUEST,
                          alse_pkg::C_ALLOC, 16'd60, p));
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h1, 16'h1, alse_pkg::T_REQUEST,
                          alse_pkg::C_EXTEND, '1, '0));
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h1, 16'h1, alse_pkg::T_RELEASE,
                          '0, '0, ~p));
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h1, 16'h1, alse_pkg::T_RELEASE,
                          '0, '0, p));
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h2, 16'h2, alse_pkg::T_DISCOVER,
                          '0, '0, '0));
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h2, 16'h2, alse_pkg::T_OFFER,
                          '0, '0, '0));
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h3, 16'h3, alse_pkg::T_DISCOVER,
                          '0, '0, '0));
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h3, 16'h3, alse_pkg::T_REQUEST,
                          alse_pkg::C_ALLOC, '0,
                          board.pair[board.find_client(32'h3, 16'h3)]));
      send_word(make_word(alse_pkg::CMD_MESSAGE, 32'h3, 16'h3, alse_pkg::T_ACK,
                          alse_pkg::C_EXTEND, '0, '0));
      send_word(make_word(alse_pkg::CMD_TICK, '0, '0, '0, '0, '0, '0));

      for (int ph = 0; ph < 5; ph++) begin
         write_lease(lease_plan[ph]);
         for (int n = 0; n < 90; n++) send_word(random_word());
      end

      req_chan.valid = 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("[address_lease_server_engine] OK");
      end else begin
         $display("[address_lease_server_engine] ERROR");
      end
      $finish;
   end
endmodule

>>> address_lease_server_engine.f
rtl/core/alse_pkg.sv
rtl/core/alse_req_if.sv
rtl/core/alse_rsp_if.sv
rtl/core/alse_cell.sv
rtl/core/address_lease_server_engine.sv
bench/tb_address_lease_server_engine.sv
